@@ hw/rtl/ukol_pkg.sv @@
// Shared types and constants for the unique-key ordered list.
// No dependencies; imported by ukol_store, unique_key_ordered_list_top and the testbench.
package ukol_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 16;

   // request codes
   localparam logic [2:0] REQ_INSERT_HEAD  = 3'd0;
   localparam logic [2:0] REQ_INSERT_AFTER = 3'd1;
   localparam logic [2:0] REQ_INSERT_TAIL  = 3'd2;
   localparam logic [2:0] REQ_DELETE       = 3'd3;
   localparam logic [2:0] REQ_DUMP         = 3'd4;

   // result status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_DUP       = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] ref_key;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [KEY_W-1:0] item_key;
      logic             item_valid;
      logic             last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      SOP_NONE,
      SOP_INSERT,
      SOP_REMOVE
   } store_op_type;

   typedef struct packed {
      store_op_type     op;
      logic [IDX_W-1:0] pos;
      logic [KEY_W-1:0] key;
   } store_ctrl_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_APPLY,
      CS_DUMP
   } ctrl_state_type;

endpackage

@@ hw/rtl/unique_key_ordered_list_top.sv @@
// Ordered list of unique 16-bit keys with insert, delete and dump requests.
// Depends on ukol_pkg and ukol_store.
//
// A request is taken when start is high and busy is low. Inserts and deletes
// walk the stored entries one per cycle through the single read port and its
// key and reference comparators, then apply the change in the apply state, the
// last state with busy high, and the single result follows in the cycle after
// it. A dump gives one result per key on consecutive cycles, head first, with
// last on the final one. Other requests, and a dump of an empty list, go
// straight to the apply state, and their result is registered from it.
// Results are shown for one cycle on rsp_strobe and cannot be held off, so a
// receiver must take them as they come.
module unique_key_ordered_list_top
   import ukol_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_payload_type req_item,
   output logic            busy,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_item
);

   ctrl_state_type   state_ff, state_in;
   req_payload_type  req_ff, req_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             key_hit_ff, key_hit_in;
   logic [IDX_W-1:0] key_pos_ff, key_pos_in;
   logic             ref_hit_ff, ref_hit_in;
   logic [IDX_W-1:0] ref_pos_ff, ref_pos_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_payload_type  rsp_item_ff, rsp_item_in;
   store_ctrl_type   store_ctrl;
   logic [KEY_W-1:0] rd_key;
   logic [CNT_W-1:0] entry_count;
   logic             accept;
   logic             scan_active;
   logic             at_tail;
   logic             is_insert;

   ukol_store u_store (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (store_ctrl),
      .rd_idx      (idx_ff[IDX_W-1:0]),
      .rd_key      (rd_key),
      .entry_count (entry_count)
   );

   assign busy        = (state_ff != CS_IDLE);
   assign accept      = start && !busy;
   assign scan_active = (idx_ff < entry_count);
   assign at_tail     = (idx_ff == entry_count - CNT_W'(1));
   assign is_insert   = (req_ff.req_type == REQ_INSERT_HEAD)  ||
                        (req_ff.req_type == REQ_INSERT_AFTER) ||
                        (req_ff.req_type == REQ_INSERT_TAIL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               case (req_item.req_type)
                  REQ_INSERT_HEAD, REQ_INSERT_AFTER, REQ_INSERT_TAIL, REQ_DELETE: begin
                     state_in = CS_SCAN;
                  end
                  REQ_DUMP: begin
                     state_in = (entry_count != '0) ? CS_DUMP : CS_APPLY;
                  end
                  default: begin
                     state_in = CS_APPLY;
                  end
               endcase
            end
         end
         CS_SCAN: begin
            if (!scan_active) begin
               state_in = CS_APPLY;
            end
         end
         CS_APPLY: begin
            state_in = CS_IDLE;
         end
         CS_DUMP: begin
            if (at_tail) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // datapath, store control and result
   always_comb begin
      req_in        = req_ff;
      idx_in        = idx_ff;
      key_hit_in    = key_hit_ff;
      key_pos_in    = key_pos_ff;
      ref_hit_in    = ref_hit_ff;
      ref_pos_in    = ref_pos_ff;
      store_ctrl    = '{op: SOP_NONE, pos: '0, key: req_ff.key};
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '{status: STATUS_OK, item_key: '0, item_valid: 1'b0, last: 1'b1};
      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               req_in = req_item;
            end
            idx_in     = '0;
            key_hit_in = 1'b0;
            ref_hit_in = 1'b0;
         end
         CS_SCAN: begin
            if (scan_active) begin
               // first match only; keys are unique anyway
               if (!key_hit_ff && rd_key == req_ff.key) begin
                  key_hit_in = 1'b1;
                  key_pos_in = idx_ff[IDX_W-1:0];
               end
               if (!ref_hit_ff && rd_key == req_ff.ref_key) begin
                  ref_hit_in = 1'b1;
                  ref_pos_in = idx_ff[IDX_W-1:0];
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         CS_APPLY: begin
            rsp_strobe_in = 1'b1;
            if (is_insert) begin
               if (key_hit_ff) begin
                  rsp_item_in.status = STATUS_DUP;
               end else if (entry_count == CNT_W'(CAPACITY)) begin
                  rsp_item_in.status = STATUS_FULL;
               end else begin
                  store_ctrl.op = SOP_INSERT;
                  if (req_ff.req_type == REQ_INSERT_HEAD) begin
                     store_ctrl.pos = '0;
                  end else if (req_ff.req_type == REQ_INSERT_AFTER && ref_hit_ff) begin
                     store_ctrl.pos = ref_pos_ff + IDX_W'(1);
                  end else begin
                     // tail, or insert-after with a missing reference
                     store_ctrl.pos = entry_count[IDX_W-1:0];
                  end
               end
            end else if (req_ff.req_type == REQ_DELETE) begin
               if (entry_count == '0) begin
                  rsp_item_in.status = STATUS_EMPTY;
               end else if (!key_hit_ff) begin
                  rsp_item_in.status = STATUS_NOT_FOUND;
               end else begin
                  store_ctrl.op  = SOP_REMOVE;
                  store_ctrl.pos = key_pos_ff;
               end
            end else if (req_ff.req_type == REQ_DUMP) begin
               rsp_item_in.status = STATUS_EMPTY;
            end
         end
         CS_DUMP: begin
            rsp_strobe_in          = 1'b1;
            rsp_item_in.item_key   = rd_key;
            rsp_item_in.item_valid = 1'b1;
            rsp_item_in.last       = at_tail;
            idx_in                 = idx_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         rsp_strobe_ff <= 1'b0;
         idx_ff        <= '0;
         key_hit_ff    <= 1'b0;
         ref_hit_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         idx_ff        <= idx_in;
         key_hit_ff    <= key_hit_in;
         ref_hit_ff    <= ref_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      key_pos_ff  <= key_pos_in;
      ref_pos_ff  <= ref_pos_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // the count never goes past the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // the entry count does not change while the list is being walked
   a_scan_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_SCAN) |=> $stable(entry_count))
      else $error("entry count changed during scan");

   // a dump streams without gaps until its last result
   a_dump_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |=> rsp_strobe)
      else $error("gap in dump results");

   // a result without a key is always the only one of its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.item_valid) |-> rsp_item.last)
      else $error("non-dump result without last");

endmodule

@@ hw/rtl/ukol_store.sv @@
// Key storage row for the ordered list: packed entries, count, one read port.
// Depends on ukol_pkg. Insert and remove shift the tail by one place in a single registered update.
module ukol_store
   import ukol_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  store_ctrl_type   ctrl,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [KEY_W-1:0] rd_key,
   output logic [CNT_W-1:0] entry_count
);

   logic [KEY_W-1:0] keys_ff [CAPACITY];
   logic [KEY_W-1:0] keys_in [CAPACITY];
   logic [KEY_W-1:0] up_keys [CAPACITY];
   logic [KEY_W-1:0] dn_keys [CAPACITY];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // neighbour taps for the one-place shifts
   always_comb begin
      up_keys[0] = keys_ff[0];
      for (int i = 1; i < CAPACITY; i++) begin
         up_keys[i] = keys_ff[i-1];
      end
      dn_keys[CAPACITY-1] = keys_ff[CAPACITY-1];
      for (int i = 0; i < CAPACITY - 1; i++) begin
         dn_keys[i] = keys_ff[i+1];
      end
   end

   always_comb begin
      keys_in  = keys_ff;
      count_in = count_ff;
      case (ctrl.op)
         SOP_INSERT: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (IDX_W'(i) == ctrl.pos) begin
                  keys_in[i] = ctrl.key;
               end else if (IDX_W'(i) > ctrl.pos) begin
                  keys_in[i] = up_keys[i];
               end
            end
            count_in = count_ff + CNT_W'(1);
         end
         SOP_REMOVE: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (IDX_W'(i) >= ctrl.pos) begin
                  keys_in[i] = dn_keys[i];
               end
            end
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      keys_ff <= keys_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_key      = keys_ff[rd_idx];
   assign entry_count = count_ff;

endmodule

@@ bench/tb_unique_key_ordered_list_top.sv @@
// Testbench for unique_key_ordered_list_top: a table of directed requests, then random
// list operations, all checked against a behavioural copy of the ordered key list.
// Depends on ukol_pkg and the RTL of unique_key_ordered_list_top.
`timescale 1ns / 1ps

module tb_unique_key_ordered_list_top;
   import ukol_pkg::*;

   localparam int          RANDOM_ITEMS = 395;
   localparam int          POOL_SIZE    = 24;
   localparam logic [2:0]  REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0]  REQ_SPARE_MID = 3'd6;
   localparam logic [2:0]  REQ_SPARE_HI  = 3'd7;

   typedef struct {
      req_payload_type item;
      int              reps;    // repeated with the key stepping by one
      bit              pinned;  // status typed in below rather than predicted
      logic [2:0]      status;
   } stim_row_type;

   logic            clock;
   logic            reset;
   logic            start;
   req_payload_type req_item;
   logic            busy;
   logic            rsp_strobe;
   rsp_payload_type rsp_item;

   // travels alongside req_item so the monitor knows a typed-in status applies
   logic            pin_expect;
   logic [2:0]      pin_status;

   logic [KEY_W-1:0] list_keys [CAPACITY];
   int               list_len;
   rsp_payload_type  awaited_results [$];
   rsp_payload_type  want_rsp;
   int               queued_before;
   int               mismatch_count;

   stim_row_type     directed_rows [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   unique_key_ordered_list_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < list_len; i++) begin
         if (list_keys[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic void await_result(logic [2:0] st, logic [KEY_W-1:0] k, logic v,
                                        logic l);
      rsp_payload_type r;
      r.status     = st;
      r.item_key   = k;
      r.item_valid = v;
      r.last       = l;
      awaited_results.push_back(r);
   endfunction

   // updates the list copy and queues every result that the request gives
   function automatic void list_apply(req_payload_type r);
      int pos;
      int hit;
      case (r.req_type)
         REQ_INSERT_HEAD, REQ_INSERT_AFTER, REQ_INSERT_TAIL: begin
            if (find_key(r.key) >= 0) begin
               await_result(STATUS_DUP, '0, 1'b0, 1'b1);
            end else if (list_len == CAPACITY) begin
               await_result(STATUS_FULL, '0, 1'b0, 1'b1);
            end else begin
               if (r.req_type == REQ_INSERT_HEAD) begin
                  pos = 0;
               end else if (r.req_type == REQ_INSERT_TAIL) begin
                  pos = list_len;
               end else begin
                  // missing reference falls back to the tail
                  hit = find_key(r.ref_key);
                  pos = (hit >= 0) ? hit + 1 : list_len;
               end
               for (int i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
               list_keys[pos] = r.key;
               list_len++;
               await_result(STATUS_OK, '0, 1'b0, 1'b1);
            end
         end
         REQ_DELETE: begin
            hit = find_key(r.key);
            if (list_len == 0) begin
               await_result(STATUS_EMPTY, '0, 1'b0, 1'b1);
            end else if (hit < 0) begin
               await_result(STATUS_NOT_FOUND, '0, 1'b0, 1'b1);
            end else begin
               for (int i = hit; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
               list_len--;
               await_result(STATUS_OK, '0, 1'b0, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (list_len == 0) begin
               await_result(STATUS_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  await_result(STATUS_OK, list_keys[i], 1'b1, i == list_len - 1);
            end
         end
         default: begin
            await_result(STATUS_OK, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   // results are checked before the request taken at the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing awaited", rsp_item, 0);
            end else begin
               want_rsp = awaited_results.pop_front();
               if (rsp_item.status !== want_rsp.status)
                  report_mismatch("status", rsp_item.status, want_rsp.status);
               if (rsp_item.item_key !== want_rsp.item_key)
                  report_mismatch("item_key", rsp_item.item_key, want_rsp.item_key);
               if (rsp_item.item_valid !== want_rsp.item_valid)
                  report_mismatch("item_valid", rsp_item.item_valid, want_rsp.item_valid);
               if (rsp_item.last !== want_rsp.last)
                  report_mismatch("last", rsp_item.last, want_rsp.last);
            end
         end
         if (start && !busy) begin
            queued_before = awaited_results.size();
            list_apply(req_item);
            if (pin_expect && awaited_results.size() == queued_before + 1)
               awaited_results[$] = '{pin_status, '0, 1'b0, 1'b1};
         end
      end
   end

   // presents one request and returns at the edge that takes it
   task automatic issue_request(req_payload_type r, bit pin, logic [2:0] st, bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 24);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_item   <= r;
      pin_expect <= pin;
      pin_status <= st;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      req_payload_type r;
      int              roll;
      bit              growing;
      bit              may_idle;

      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      pin_expect     = 1'b0;
      pin_status     = STATUS_OK;
      list_len       = 0;
      mismatch_count = 0;

      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(0, 65535));

      directed_rows.push_back('{'{REQ_DUMP,         16'h0000, 16'h0000},  1, 1, STATUS_EMPTY});
      directed_rows.push_back('{'{REQ_DELETE,       16'h0000, 16'h0000},  1, 1, STATUS_EMPTY});
      directed_rows.push_back('{'{REQ_INSERT_TAIL,  16'h0000, 16'hFFFF},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_HEAD,  16'hFFFF, 16'h0000},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_HEAD,  16'hFFFF, 16'hFFFF},  1, 1, STATUS_DUP});
      directed_rows.push_back('{'{REQ_INSERT_AFTER, 16'h1234, 16'h0000},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_AFTER, 16'h8000, 16'hFFFF},  1, 0, STATUS_OK});
      // reference absent, then reference equal to the key itself
      directed_rows.push_back('{'{REQ_INSERT_AFTER, 16'h00FF, 16'h5555},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_AFTER, 16'h4321, 16'h4321},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_DELETE,       16'h7777, 16'h0000},  1, 1, STATUS_NOT_FOUND});
      directed_rows.push_back('{'{REQ_DUMP,         16'hFFFF, 16'hFFFF},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_DELETE,       16'hFFFF, 16'h0000},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_DELETE,       16'h4321, 16'h0000},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_SPARE_LO,     16'hFFFF, 16'hFFFF},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_SPARE_MID,    16'h0000, 16'h0000},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_SPARE_HI,     16'hA5A5, 16'h5A5A},  1, 1, STATUS_OK});
      // fill to capacity
      directed_rows.push_back('{'{REQ_INSERT_TAIL,  16'h0A00, 16'h0000}, 12, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_HEAD,  16'hBEEF, 16'h0000},  1, 1, STATUS_FULL});
      // duplicate takes precedence over full
      directed_rows.push_back('{'{REQ_INSERT_TAIL,  16'h0000, 16'h0000},  1, 1, STATUS_DUP});
      directed_rows.push_back('{'{REQ_DUMP,         16'h0000, 16'h0000},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_DELETE,       16'h0A05, 16'h0000},  1, 1, STATUS_OK});
      directed_rows.push_back('{'{REQ_INSERT_AFTER, 16'hC0DE, 16'h0A0B},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_DUMP,         16'h0000, 16'h0000},  1, 0, STATUS_OK});
      directed_rows.push_back('{'{REQ_DELETE,       16'h0000, 16'h0000},  1, 1, STATUS_OK});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         for (int j = 0; j < directed_rows[i].reps; j++) begin
            r     = directed_rows[i].item;
            r.key = r.key + KEY_W'(j);
            issue_request(r, directed_rows[i].pinned, directed_rows[i].status, 1'b1);
         end
      end

      // alternate spells that fill the list and spells that drain it
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         growing  = ((n / 40) % 2) == 0;
         may_idle = !(n >= 150 && n < 250);
         roll     = $urandom_range(0, 99);
         r.key     = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : KEY_W'($urandom_range(0, 65535));
         r.ref_key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : KEY_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 19) == 0) r.ref_key = r.key;
         if (roll < (growing ? 20 : 8))       r.req_type = REQ_INSERT_HEAD;
         else if (roll < (growing ? 40 : 16)) r.req_type = REQ_INSERT_AFTER;
         else if (roll < (growing ? 58 : 24)) r.req_type = REQ_INSERT_TAIL;
         else if (roll < 75)                  r.req_type = REQ_DELETE;
         else if (roll < 90)                  r.req_type = REQ_DUMP;
         else if (roll < 95)
            r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
         else                                 r.req_type = REQ_DELETE;
         issue_request(r, 1'b0, STATUS_OK, may_idle);
      end
      start      <= 1'b0;
      pin_expect <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/ukol_pkg.sv
hw/rtl/ukol_store.sv
hw/rtl/unique_key_ordered_list_top.sv
bench/tb_unique_key_ordered_list_top.sv
